// ===== rtl/core/bmpfb_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpfb_pkg
// Shared constants and types of the BMP stream to framebuffer unpacker.
// ----------------------------------------------------------------------------
package bmpfb_pkg;

  // default geometry
  localparam int BMPFB_FRAME_WIDTH   = 800;
  localparam int BMPFB_FRAME_HEIGHT  = 480;
  localparam int BMPFB_MAX_IMAGE_DIM = 4096;
  localparam int BMPFB_QUEUE_DEPTH   = 4;

  // header layout
  localparam logic [7:0] SIG_BYTE0    = 8'h42;
  localparam logic [7:0] SIG_BYTE1    = 8'h4D;
  localparam logic [5:0] HDR_SIG0     = 6'd0;
  localparam logic [5:0] HDR_SIG1     = 6'd1;
  localparam logic [5:0] HDR_WIDTH    = 6'h12;
  localparam logic [5:0] HDR_HEIGHT   = 6'h16;
  localparam logic [5:0] HDR_DEPTH    = 6'h1C;
  localparam logic [5:0] PIXEL_START  = 6'd54;
  localparam logic [5:0] PARSE_DONE   = 6'd55;

  localparam logic [15:0] DEPTH_24    = 16'd24;
  localparam logic [15:0] DEPTH_32    = 16'd32;

  // configuration register indexes
  localparam logic CFG_ORIGIN_X = 1'b0;
  localparam logic CFG_ORIGIN_Y = 1'b1;

  localparam int CFG_DATA_W = 10;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/core/bmpfb_if.sv =====
// ----------------------------------------------------------------------------
// bmpfb stream interfaces
// Byte input channel and pixel result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmpfb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       file_start;

  modport source (output valid, output in_byte, output file_start, input ready);
  modport sink   (input valid, input in_byte, input file_start, output ready);
endinterface

interface bmpfb_out_if;
  logic        valid;
  logic        ready;
  logic [18:0] pixel_address;
  logic [31:0] pixel_color;
  logic        off_frame;
  logic        signature_bad;

  modport source (output valid, output pixel_address, output pixel_color,
                  output off_frame, output signature_bad, input ready);
  modport sink   (input valid, input pixel_address, input pixel_color,
                  input off_frame, input signature_bad, output ready);
endinterface

// ===== rtl/core/bmpfb_front.sv =====
// ----------------------------------------------------------------------------
// bmpfb_front
// Header parser and pixel unpacker: one byte per beat, pushes finished pixels.
// ----------------------------------------------------------------------------
module bmpfb_front
  import bmpfb_pkg::*;
#(
  parameter int MAX_IMAGE_DIM = BMPFB_MAX_IMAGE_DIM,
  parameter int DIM_W         = $clog2(MAX_IMAGE_DIM),
  parameter int ITEM_W        = 32 + 2 * DIM_W + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  bmpfb_in_if.sink          in_ch,
  input  q_stat_t           q_stat,
  output logic              push,
  output logic [ITEM_W-1:0] push_data
);

  logic [5:0]       offset_r, offset_nxt;
  logic [31:0]      width_r, width_nxt;
  logic [31:0]      height_r, height_nxt;
  logic [15:0]      depth_r, depth_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [23:0]      asm_r, asm_nxt;
  logic [1:0]       pad_r, pad_nxt;
  logic             sig_r, sig_nxt;

  logic [5:0]       cur_offset;
  logic [31:0]      cur_width, cur_height;
  logic [15:0]      cur_depth;
  logic [DIM_W-1:0] cur_row, cur_col;
  logic [1:0]       cur_cnt, cur_pad;
  logic             cur_sig;
  logic             fire, bpp4, last, img_ok;
  logic [5:0]       rel_w, rel_h, rel_d;
  logic [DIM_W:0]   col_inc;
  logic [7:0]       b;
  logic [31:0]      color;

  assign in_ch.ready = !q_stat.full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;

  // a file start wipes the parse state before this byte is looked at
  always_comb begin
    if (in_ch.file_start) begin
      cur_offset = '0;
      cur_width  = '0;
      cur_height = '0;
      cur_depth  = '0;
      cur_row    = '0;
      cur_col    = '0;
      cur_cnt    = '0;
      cur_pad    = '0;
      cur_sig    = 1'b0;
    end else begin
      cur_offset = offset_r;
      cur_width  = width_r;
      cur_height = height_r;
      cur_depth  = depth_r;
      cur_row    = row_r;
      cur_col    = col_r;
      cur_cnt    = cnt_r;
      cur_pad    = pad_r;
      cur_sig    = sig_r;
    end
  end

  assign rel_w   = cur_offset - HDR_WIDTH;
  assign rel_h   = cur_offset - HDR_HEIGHT;
  assign rel_d   = cur_offset - HDR_DEPTH;
  assign bpp4    = (cur_depth == DEPTH_32);
  assign last    = bpp4 ? (cur_cnt == 2'd3) : (cur_cnt == 2'd2);
  assign col_inc = {1'b0, cur_col} + 1'b1;
  assign img_ok  = (cur_depth == DEPTH_24 || cur_depth == DEPTH_32)
                && (cur_width != 32'd0) && (cur_width <= 32'(MAX_IMAGE_DIM))
                && (cur_height != 32'd0) && (cur_height <= 32'(MAX_IMAGE_DIM));

  always_comb begin
    offset_nxt = offset_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    depth_nxt  = depth_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    cnt_nxt    = cnt_r;
    asm_nxt    = asm_r;
    pad_nxt    = pad_r;
    sig_nxt    = sig_r;
    push       = 1'b0;
    color      = '0;
    if (fire) begin
      offset_nxt = cur_offset;
      width_nxt  = cur_width;
      height_nxt = cur_height;
      depth_nxt  = cur_depth;
      row_nxt    = cur_row;
      col_nxt    = cur_col;
      cnt_nxt    = cur_cnt;
      pad_nxt    = cur_pad;
      sig_nxt    = cur_sig;
      if (cur_offset < PIXEL_START) begin
        if (cur_offset == HDR_SIG0 && b != SIG_BYTE0) sig_nxt = 1'b1;
        if (cur_offset == HDR_SIG1 && b != SIG_BYTE1) sig_nxt = 1'b1;
        if (cur_offset >= HDR_WIDTH && cur_offset < HDR_HEIGHT)
          width_nxt[{rel_w[1:0], 3'b000} +: 8] = b;
        if (cur_offset >= HDR_HEIGHT && cur_offset < HDR_HEIGHT + 6'd4)
          height_nxt[{rel_h[1:0], 3'b000} +: 8] = b;
        if (cur_offset >= HDR_DEPTH && cur_offset < HDR_DEPTH + 6'd2)
          depth_nxt[{rel_d[0], 3'b000} +: 8] = b;
        if (cur_offset == PIXEL_START - 6'd1) begin
          col_nxt = '0;
          cnt_nxt = '0;
          pad_nxt = '0;
          if (img_ok) begin
            row_nxt    = DIM_W'(cur_height - 32'd1);
            offset_nxt = PIXEL_START;
          end else begin
            row_nxt    = '0;
            offset_nxt = PARSE_DONE;
          end
        end else begin
          offset_nxt = cur_offset + 6'd1;
        end
      end else if (cur_offset == PIXEL_START) begin
        if (cur_pad != 2'd0) begin
          pad_nxt = cur_pad - 2'd1;
        end else begin
          if (cur_cnt != 2'd3) asm_nxt[{cur_cnt, 3'b000} +: 8] = b;
          if (!last) begin
            cnt_nxt = cur_cnt + 2'd1;
          end else begin
            push    = 1'b1;
            color   = {bpp4 ? b : 8'h00, asm_nxt};
            cnt_nxt = '0;
            if (32'(col_inc) >= cur_width) begin
              col_nxt = '0;
              if (cur_row == '0) begin
                offset_nxt = PARSE_DONE;
              end else begin
                row_nxt = cur_row - 1'b1;
                // 3-byte pixels leave width mod 4 padding bytes per row
                pad_nxt = bpp4 ? 2'd0 : cur_width[1:0];
              end
            end else begin
              col_nxt = col_inc[DIM_W-1:0];
            end
          end
        end
      end
    end
  end

  assign push_data = {cur_sig, cur_row, cur_col, color};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      width_r  <= '0;
      height_r <= '0;
      depth_r  <= '0;
      row_r    <= '0;
      col_r    <= '0;
      cnt_r    <= '0;
      pad_r    <= '0;
      sig_r    <= 1'b0;
    end else begin
      offset_r <= offset_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      depth_r  <= depth_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      cnt_r    <= cnt_nxt;
      pad_r    <= pad_nxt;
      sig_r    <= sig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    asm_r <= asm_nxt;
  end

  // padding is only pending while pixel data is being unpacked
  a_pad_in_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    pad_r != 2'd0 |-> offset_r == PIXEL_START)
    else $error("row padding pending outside pixel data");

  a_push_only_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> fire && cur_offset == PIXEL_START && cur_pad == 2'd0)
    else $error("pixel pushed outside pixel data");

endmodule

// ===== rtl/core/bmpfb_queue.sv =====
// ----------------------------------------------------------------------------
// bmpfb_queue
// Short FIFO between the parser and the address stage.
// ----------------------------------------------------------------------------
module bmpfb_queue
  import bmpfb_pkg::*;
#(
  parameter int WIDTH = 57,
  parameter int DEPTH = BMPFB_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_stat_t          q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push)
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  // the parser must never offer a beat the queue cannot hold
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into a full queue");

endmodule

// ===== rtl/core/bmpfb_back.sv =====
// ----------------------------------------------------------------------------
// bmpfb_back
// Places each pixel on the frame: address, off-frame flag, output register.
// ----------------------------------------------------------------------------
module bmpfb_back
  import bmpfb_pkg::*;
#(
  parameter int FRAME_WIDTH  = BMPFB_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = BMPFB_FRAME_HEIGHT,
  parameter int DIM_W        = $clog2(BMPFB_MAX_IMAGE_DIM),
  parameter int ITEM_W       = 32 + 2 * DIM_W + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [9:0]        origin_x,
  input  logic [8:0]        origin_y,
  input  q_stat_t           q_stat,
  input  logic [ITEM_W-1:0] pop_data,
  output logic              pop,
  bmpfb_out_if.source       out_ch
);

  localparam int X_W = ((DIM_W > 10) ? DIM_W : 10) + 1;
  localparam int Y_W = ((DIM_W > 9) ? DIM_W : 9) + 1;

  logic             sig;
  logic [DIM_W-1:0] row, col;
  logic [31:0]      color;
  logic [X_W-1:0]   fx;
  logic [Y_W-1:0]   fy;
  logic [31:0]      addr_full;
  logic             off, load;

  logic             valid_r;
  logic [18:0]      addr_r;
  logic [31:0]      color_r;
  logic             off_r, sig_r;

  assign {sig, row, col, color} = pop_data;

  assign fx        = X_W'(origin_x) + X_W'(col);
  assign fy        = Y_W'(origin_y) + Y_W'(row);
  assign off       = (32'(fx) >= 32'(FRAME_WIDTH)) || (32'(fy) >= 32'(FRAME_HEIGHT));
  assign addr_full = 32'(fx) + 32'(fy) * 32'(FRAME_WIDTH);

  assign load = !valid_r || out_ch.ready;
  assign pop  = load && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      addr_r  <= off ? 19'd0 : addr_full[18:0];
      color_r <= color;
      off_r   <= off;
      sig_r   <= sig;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.pixel_address = addr_r;
  assign out_ch.pixel_color   = color_r;
  assign out_ch.off_frame     = off_r;
  assign out_ch.signature_bad = sig_r;

  a_off_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && off_r |-> addr_r == 19'd0)
    else $error("off-frame pixel carries an address");

endmodule

// ===== rtl/core/bmp_stream_to_framebuffer.sv =====
// ----------------------------------------------------------------------------
// bmp_stream_to_framebuffer
// Parses a BMP byte stream and emits framebuffer address and ARGB color
// for every 24- or 32-bit pixel.
// Throughput: one byte per cycle while the queue is not full, set by the
// single-beat header/pixel parser. A pixel's last byte writes it into the
// queue; it is then popped into the output register with its multiply-add address.
// Reset: synchronous active-low rst_n clears parse state, queue and origins.
// ----------------------------------------------------------------------------
module bmp_stream_to_framebuffer
  import bmpfb_pkg::*;
#(
  parameter int FRAME_WIDTH   = BMPFB_FRAME_WIDTH,
  parameter int FRAME_HEIGHT  = BMPFB_FRAME_HEIGHT,
  parameter int MAX_IMAGE_DIM = BMPFB_MAX_IMAGE_DIM
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bmpfb_in_if.sink              in_ch,
  bmpfb_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DIM_W  = $clog2(MAX_IMAGE_DIM);
  localparam int ITEM_W = 32 + 2 * DIM_W + 1;

  logic [9:0]        origin_x_r;
  logic [8:0]        origin_y_r;
  logic              push, pop;
  logic [ITEM_W-1:0] push_data, pop_data;
  q_stat_t           q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X: origin_x_r <= cfg_wdata[9:0];
        CFG_ORIGIN_Y: origin_y_r <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  bmpfb_front #(
    .MAX_IMAGE_DIM (MAX_IMAGE_DIM),
    .DIM_W         (DIM_W),
    .ITEM_W        (ITEM_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  bmpfb_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (BMPFB_QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  bmpfb_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .DIM_W        (DIM_W),
    .ITEM_W       (ITEM_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .origin_x (origin_x_r),
    .origin_y (origin_y_r),
    .q_stat   (q_stat),
    .pop_data (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// ===== sim/bmpfb_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// bmpfb_pixel_checker
// Watches the byte, pixel and register ports of the BMP unpacker. It keeps
// its own parse of the byte stream and a queue of expected pixel writes, and
// compares every pixel beat against the oldest entry, counting failures.
// ----------------------------------------------------------------------------
module bmpfb_pixel_checker
  import bmpfb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  bmpfb_in_if                   in_mon,
  bmpfb_out_if                  out_mon,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [18:0] addr;
    logic [31:0] color;
    logic        off;
    logic        sig;
  } pixel_t;

  pixel_t pixel_q[$];

  // origin registers
  logic [9:0]  org_x;
  logic [8:0]  org_y;

  // parse state
  logic [5:0]  hdr_pos;
  logic [31:0] img_w;
  logic [31:0] img_h;
  logic [15:0] depth;
  logic [12:0] row;
  logic [12:0] col;
  logic [1:0]  pix_cnt;
  logic [23:0] pix_acc;
  logic [1:0]  pad_left;
  logic        sig_bad;

  function automatic void clear_parse();
    hdr_pos  = '0;
    img_w    = '0;
    img_h    = '0;
    depth    = '0;
    row      = '0;
    col      = '0;
    pix_cnt  = '0;
    pix_acc  = '0;
    pad_left = '0;
    sig_bad  = 1'b0;
  endfunction

  function automatic void predict_beat(input logic [7:0] b, input logic fs);
    int          p;
    int          bpp;
    int unsigned fx;
    int unsigned fy;
    logic        off;
    pixel_t      px;
    if (fs) clear_parse();
    p = int'(hdr_pos);
    if (hdr_pos < PIXEL_START) begin
      if (hdr_pos == HDR_SIG0 && b != SIG_BYTE0) sig_bad = 1'b1;
      if (hdr_pos == HDR_SIG1 && b != SIG_BYTE1) sig_bad = 1'b1;
      if (p >= int'(HDR_WIDTH) && p < int'(HDR_WIDTH) + 4)
        img_w[8*(p - int'(HDR_WIDTH)) +: 8] = b;
      if (p >= int'(HDR_HEIGHT) && p < int'(HDR_HEIGHT) + 4)
        img_h[8*(p - int'(HDR_HEIGHT)) +: 8] = b;
      if (p >= int'(HDR_DEPTH) && p < int'(HDR_DEPTH) + 2)
        depth[8*(p - int'(HDR_DEPTH)) +: 8] = b;
      if (hdr_pos == PIXEL_START - 6'd1) begin
        col      = '0;
        pix_cnt  = '0;
        pix_acc  = '0;
        pad_left = '0;
        if ((depth == DEPTH_24 || depth == DEPTH_32) &&
            img_w != 0 && img_w <= BMPFB_MAX_IMAGE_DIM &&
            img_h != 0 && img_h <= BMPFB_MAX_IMAGE_DIM) begin
          row     = 13'(img_h - 32'd1);
          hdr_pos = PIXEL_START;
        end else begin
          row     = '0;
          hdr_pos = PARSE_DONE;
        end
      end else begin
        hdr_pos = hdr_pos + 6'd1;
      end
    end else if (hdr_pos == PIXEL_START) begin
      if (pad_left != 2'd0) begin
        pad_left = pad_left - 2'd1;
      end else begin
        bpp = (depth == DEPTH_32) ? 4 : 3;
        if (pix_cnt < 2'd3) pix_acc[8*pix_cnt +: 8] = b;
        if (int'(pix_cnt) + 1 < bpp) begin
          pix_cnt = pix_cnt + 2'd1;
        end else begin
          fx = org_x + col;
          fy = org_y + row;
          off = fx >= BMPFB_FRAME_WIDTH || fy >= BMPFB_FRAME_HEIGHT;
          px.addr  = off ? '0 : 19'(fx + fy * BMPFB_FRAME_WIDTH);
          px.color = {(bpp == 4) ? b : 8'h00, pix_acc};
          px.off   = off;
          px.sig   = sig_bad;
          pixel_q.push_back(px);
          pix_cnt = '0;
          pix_acc = '0;
          col = col + 13'd1;
          if (col >= img_w) begin
            col = '0;
            if (row == 13'd0) begin
              hdr_pos = PARSE_DONE;
            end else begin
              // rows are padded to a multiple of 4 bytes
              row      = row - 13'd1;
              pad_left = 2'd0 - 2'(bpp * int'(img_w[1:0]));
            end
          end
        end
      end
    end
  endfunction

  always @(posedge clk) begin : monitor
    pixel_t want;
    pixel_t got;
    if (!rst_n) begin
      clear_parse();
      org_x = '0;
      org_y = '0;
      pixel_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_ORIGIN_X) org_x = cfg_wdata[9:0];
        else                           org_y = cfg_wdata[8:0];
      end
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.pixel_address, out_mon.pixel_color,
                out_mon.off_frame, out_mon.signature_bad};
        if (pixel_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected pixel beat: addr %0d color %08h off %0b sig %0b",
                     got.addr, got.color, got.off, got.sig);
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          if (want !== got) begin
            if (fail_count < 10)
              $display("pixel mismatch exp/act: addr %0d/%0d color %08h/%08h off %0b/%0b sig %0b/%0b",
                       want.addr, got.addr, want.color, got.color,
                       want.off, got.off, want.sig, got.sig);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_beat(in_mon.in_byte, in_mon.file_start);
    end
    pending = pixel_q.size();
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives BMP files into the unpacker byte by byte: directed headers for each
// depth, padding, signature and rejection case, then random well-formed,
// truncated and rejected files under several origin and flow-control
// settings, with one long output hold-off. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb;
  import bmpfb_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int sent_beats;
  int send_idle_pct;
  int recv_stall_pct;
  logic hold_go;

  bmpfb_in_if  in_ch();
  bmpfb_out_if out_ch();

  always #1 clk = ~clk;

  bmp_stream_to_framebuffer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bmpfb_pixel_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // pixel sink with random stalls and one long hold-off
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int row_span(input int w, input logic [15:0] d);
    int bpp;
    bpp = (d == DEPTH_32) ? 4 : 3;
    return ((bpp * w + 3) / 4) * 4;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.in_byte    <= b;
    in_ch.file_start <= fs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_beats++;
  endtask

  // header of 54 bytes, then pixel bytes; len may cut the file short
  task automatic send_bmp(input logic [7:0] s0, input logic [7:0] s1,
                          input logic [31:0] w, input logic [31:0] h,
                          input logic [15:0] d, input int len,
                          input logic mark, input int fill);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      if (i == int'(HDR_SIG0))
        b = s0;
      else if (i == int'(HDR_SIG1))
        b = s1;
      else if (i >= int'(HDR_WIDTH) && i < int'(HDR_WIDTH) + 4)
        b = w[8*(i - int'(HDR_WIDTH)) +: 8];
      else if (i >= int'(HDR_HEIGHT) && i < int'(HDR_HEIGHT) + 4)
        b = h[8*(i - int'(HDR_HEIGHT)) +: 8];
      else if (i >= int'(HDR_DEPTH) && i < int'(HDR_DEPTH) + 2)
        b = d[8*(i - int'(HDR_DEPTH)) +: 8];
      send_beat(b, mark && i == 0);
    end
  endtask

  task automatic send_random_file();
    int          kind;
    int          body;
    logic [31:0] w;
    logic [31:0] h;
    logic [15:0] d;
    logic [7:0]  s0;
    logic [7:0]  s1;
    kind = $urandom_range(99);
    w  = $urandom_range(1, 7);
    h  = $urandom_range(1, 4);
    d  = $urandom_range(1) ? DEPTH_32 : DEPTH_24;
    s0 = ($urandom_range(9) == 0) ? 8'($urandom) : SIG_BYTE0;
    s1 = ($urandom_range(9) == 0) ? 8'($urandom) : SIG_BYTE1;
    body = int'(h) * row_span(int'(w), d);
    if (kind < 70) begin
      send_bmp(s0, s1, w, h, d, int'(PIXEL_START) + body + $urandom_range(0, 4), 1'b1, -1);
    end else if (kind < 80) begin
      // next file_start lands mid-header or mid-pixels
      send_bmp(s0, s1, w, h, d, $urandom_range(1, int'(PIXEL_START) + body - 1), 1'b1, -1);
    end else if (kind < 90) begin
      case ($urandom_range(5))
        0: w = 32'd0;
        1: h = 32'd0;
        2: h = 32'd0 - h;
        3: w = 32'(BMPFB_MAX_IMAGE_DIM + 1 + $urandom_range(0, 1000));
        4: d = 16'($urandom);
        default: d = {8'($urandom_range(1, 255)), d[7:0]};
      endcase
      send_bmp(s0, s1, w, h, d, int'(PIXEL_START) + $urandom_range(0, 8), 1'b1, -1);
    end else begin
      case ($urandom_range(2))
        0: w = 32'(BMPFB_MAX_IMAGE_DIM);
        1: h = 32'(BMPFB_MAX_IMAGE_DIM);
        default: begin
          w = $urandom_range(8, BMPFB_MAX_IMAGE_DIM);
          h = $urandom_range(5, BMPFB_MAX_IMAGE_DIM);
        end
      endcase
      send_bmp(s0, s1, w, h, d, int'(PIXEL_START) + $urandom_range(1, 80), 1'b1, -1);
    end
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // every expected pixel has arrived and the pipeline has settled
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int ox, input int oy, input int idle,
                           input int stall, input int nbeats);
    int stop;
    wait_idle();
    write_reg(CFG_ORIGIN_X, CFG_DATA_W'(ox));
    write_reg(CFG_ORIGIN_Y, CFG_DATA_W'(oy));
    send_idle_pct  <= idle;
    recv_stall_pct <= stall;
    stop = sent_beats + nbeats;
    while (sent_beats < stop) send_random_file();
  endtask

  initial begin : stimulus
    in_ch.valid      <= 1'b0;
    in_ch.in_byte    <= 8'h00;
    in_ch.file_start <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_ORIGIN_X;
    cfg_wdata        <= '0;
    hold_go          <= 1'b0;
    send_idle_pct    <= 0;
    recv_stall_pct   <= 0;
    sent_beats        = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first file with no file_start, origins at reset value
    send_bmp(SIG_BYTE0, SIG_BYTE1, 2, 2, DEPTH_24, int'(PIXEL_START) + 16, 1'b0, -1);
    send_bmp(8'h00, SIG_BYTE1, 3, 2, DEPTH_32, int'(PIXEL_START) + 26, 1'b1, -1);
    send_bmp(SIG_BYTE0, 8'hFF, 3, 2, DEPTH_24, int'(PIXEL_START) + 24, 1'b1, -1);
    send_bmp(SIG_BYTE0, SIG_BYTE1, 1, 3, DEPTH_24, int'(PIXEL_START) + 12, 1'b1, -1);
    send_bmp(SIG_BYTE0, SIG_BYTE1, 1, 1, DEPTH_32, int'(PIXEL_START) + 4, 1'b1, 8'hFF);
    send_bmp(SIG_BYTE0, SIG_BYTE1, 1, 1, DEPTH_32, int'(PIXEL_START) + 4, 1'b1, 8'h00);
    // rejected headers
    send_bmp(SIG_BYTE0, SIG_BYTE1, 2, 2, 16'd16, int'(PIXEL_START) + 6, 1'b1, -1);
    send_bmp(SIG_BYTE0, SIG_BYTE1, 0, 2, DEPTH_24, int'(PIXEL_START) + 6, 1'b1, -1);
    send_bmp(SIG_BYTE0, SIG_BYTE1, 2, 32'hFFFF_FFFE, DEPTH_24, int'(PIXEL_START) + 6,
             1'b1, -1);
    send_bmp(SIG_BYTE0, SIG_BYTE1, BMPFB_MAX_IMAGE_DIM + 1, 1, DEPTH_32,
             int'(PIXEL_START) + 6, 1'b1, -1);
    send_bmp(SIG_BYTE0, SIG_BYTE1, 2, 2, 16'h0118, int'(PIXEL_START) + 6, 1'b1, -1);
    // largest accepted sizes, cut short by the next file
    send_bmp(SIG_BYTE0, SIG_BYTE1, BMPFB_MAX_IMAGE_DIM, 1, DEPTH_24,
             int'(PIXEL_START) + 40, 1'b1, -1);
    send_bmp(SIG_BYTE0, SIG_BYTE1, 1, BMPFB_MAX_IMAGE_DIM, DEPTH_32,
             int'(PIXEL_START) + 40, 1'b1, -1);
    // restart in the middle of a header
    send_bmp(SIG_BYTE0, SIG_BYTE1, 2, 2, DEPTH_24, 20, 1'b1, -1);
    send_bmp(SIG_BYTE0, SIG_BYTE1, 2, 1, DEPTH_32, int'(PIXEL_START) + 8, 1'b1, -1);

    run_phase($urandom_range(799), $urandom_range(479), 0, 0, 100);
    run_phase(799, 479, 51, 0, 100);
    run_phase(795, 477, 0, 51, 100);
    run_phase(0, 0, 37, 37, 100);

    // long output hold-off while bytes keep coming
    wait_idle();
    write_reg(CFG_ORIGIN_X, CFG_DATA_W'($urandom_range(799)));
    write_reg(CFG_ORIGIN_Y, CFG_DATA_W'($urandom_range(479)));
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    hold_go        <= 1'b1;
    send_bmp(SIG_BYTE0, SIG_BYTE1, 4, 8, DEPTH_32, int'(PIXEL_START) + 128, 1'b1, -1);

    wait_idle();
    if (fail_count == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bmpfb_pkg.sv
rtl/core/bmpfb_if.sv
rtl/core/bmpfb_front.sv
rtl/core/bmpfb_queue.sv
rtl/core/bmpfb_back.sv
rtl/core/bmp_stream_to_framebuffer.sv
sim/bmpfb_pixel_checker.sv
sim/tb.sv
